/* rtl/core/pidaw_pkg.sv */
// Shared types and constants for the PID controller with integral anti-windup.
package pidaw_pkg;

   // Field widths.
   localparam int DATA_W   = 16;
   localparam int ERR_W    = 17;
   localparam int DERIV_W  = 18;
   localparam int INTEG_W  = 32;
   localparam int FACTOR_W = 9;

   // Shared multiplier operand and result widths.
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 50;
   localparam int FRAC_W  = 8;
   localparam int RAW_W   = ACC_W - FRAC_W;

   // Configuration register indexes.
   localparam logic [2:0] REG_GAIN_P     = 3'd0;
   localparam logic [2:0] REG_GAIN_I     = 3'd1;
   localparam logic [2:0] REG_GAIN_D     = 3'd2;
   localparam logic [2:0] REG_OUT_MIN    = 3'd3;
   localparam logic [2:0] REG_OUT_MAX    = 3'd4;
   localparam logic [2:0] REG_WINDUP     = 3'd5;
   localparam logic [2:0] REG_TARGET     = 3'd6;
   localparam logic [2:0] REG_RUN_ENABLE = 3'd7;

   // Accumulator operations of the shared unit.
   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;

   // Current register settings.
   typedef struct packed {
      logic [DATA_W-1:0]   gain_p;
      logic [DATA_W-1:0]   gain_i;
      logic [DATA_W-1:0]   gain_d;
      logic [DATA_W-1:0]   out_min;
      logic [DATA_W-1:0]   out_max;
      logic [FACTOR_W-1:0] windup_factor;
      logic [DATA_W-1:0]   target;
      logic                run_enable;
   } cfg_type;

   // One command to the shared multiply-accumulate unit.
   typedef struct packed {
      logic [MUL_A_W-1:0] mul_a;
      logic [MUL_B_W-1:0] mul_b;
      logic [1:0]         acc_op;
   } mac_ctl_type;

endpackage

/* rtl/core/pidaw_csr.sv */
// APB-style register file holding gains, limits, windup factor, set point and enable.
module pidaw_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output pidaw_pkg::cfg_type   cfg
);

   pidaw_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]         index;
   logic               write_en;

   assign index    = paddr[4:2];
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            pidaw_pkg::REG_GAIN_P:     cfg_in.gain_p        = pwdata[15:0];
            pidaw_pkg::REG_GAIN_I:     cfg_in.gain_i        = pwdata[15:0];
            pidaw_pkg::REG_GAIN_D:     cfg_in.gain_d        = pwdata[15:0];
            pidaw_pkg::REG_OUT_MIN:    cfg_in.out_min       = pwdata[15:0];
            pidaw_pkg::REG_OUT_MAX:    cfg_in.out_max       = pwdata[15:0];
            pidaw_pkg::REG_WINDUP:     cfg_in.windup_factor = pwdata[8:0];
            pidaw_pkg::REG_TARGET:     cfg_in.target        = pwdata[15:0];
            pidaw_pkg::REG_RUN_ENABLE: cfg_in.run_enable    = pwdata[0];
            default:                   cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p        <= 16'h0000;
         cfg_ff.gain_i        <= 16'h0000;
         cfg_ff.gain_d        <= 16'h0000;
         cfg_ff.out_min       <= 16'h8000;
         cfg_ff.out_max       <= 16'h7FFF;
         cfg_ff.windup_factor <= 9'd26;
         cfg_ff.target        <= 16'h0000;
         cfg_ff.run_enable    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read mux.
   always_comb begin
      unique case (index)
         pidaw_pkg::REG_GAIN_P:     prdata = {16'd0, cfg_ff.gain_p};
         pidaw_pkg::REG_GAIN_I:     prdata = {16'd0, cfg_ff.gain_i};
         pidaw_pkg::REG_GAIN_D:     prdata = {16'd0, cfg_ff.gain_d};
         pidaw_pkg::REG_OUT_MIN:    prdata = {16'd0, cfg_ff.out_min};
         pidaw_pkg::REG_OUT_MAX:    prdata = {16'd0, cfg_ff.out_max};
         pidaw_pkg::REG_WINDUP:     prdata = {23'd0, cfg_ff.windup_factor};
         pidaw_pkg::REG_TARGET:     prdata = {16'd0, cfg_ff.target};
         pidaw_pkg::REG_RUN_ENABLE: prdata = {31'd0, cfg_ff.run_enable};
         default:                   prdata = 32'd0;
      endcase
   end

endmodule

/* rtl/core/pidaw_mac.sv */
// Shared signed multiplier with a registered product and a wide accumulator.
module pidaw_mac (
   input  logic                                clock,
   input  pidaw_pkg::mac_ctl_type              ctl,
   output logic signed [pidaw_pkg::PROD_W-1:0] prod,
   output logic signed [pidaw_pkg::ACC_W-1:0]  acc
);

   logic signed [pidaw_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [pidaw_pkg::ACC_W-1:0]  acc_ff, acc_in, prod_ext;

   // One multiply per cycle, registered before any use.
   assign prod_in  = $signed(ctl.mul_a) * $signed(ctl.mul_b);
   assign prod_ext = pidaw_pkg::ACC_W'(prod_ff);

   // The accumulator takes the previous cycle's product.
   always_comb begin
      unique case (ctl.acc_op)
         pidaw_pkg::ACC_LOAD: acc_in = prod_ext;
         pidaw_pkg::ACC_ADD:  acc_in = acc_ff + prod_ext;
         default:             acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

/* rtl/core/pid_controller_antiwindup.sv */
// Top level of the PID controller with integral anti-windup.
// An enabled sample steps through WIND, INTEG, PI, PD, SUM and CLAMP before its result is registered;
// a disabled one through OFF. Its four products share one multiplier, so no new sample is taken
// until the last one is through. A result still waiting holds the block in its last step.
// Reset is synchronous: gains zero, limits full range, windup factor 26, loop disabled,
// and integral, last error and last drive cleared.
module pid_controller_antiwindup (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_measured,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_drive,
   output logic        rsp_at_limit,
   output logic        rsp_idle_flag,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WIND  = 3'd1;
   localparam logic [2:0] S_INTEG = 3'd2;
   localparam logic [2:0] S_PI    = 3'd3;
   localparam logic [2:0] S_PD    = 3'd4;
   localparam logic [2:0] S_SUM   = 3'd5;
   localparam logic [2:0] S_CLAMP = 3'd6;
   localparam logic [2:0] S_OFF   = 3'd7;

   pidaw_pkg::cfg_type     cfg;
   pidaw_pkg::mac_ctl_type mac_ctl;

   logic signed [pidaw_pkg::PROD_W-1:0] prod;
   logic signed [pidaw_pkg::ACC_W-1:0]  acc;

   logic [2:0]  state_ff, state_in;
   logic [16:0] err_ff, err_in;
   logic [17:0] deriv_ff, deriv_in;
   logic        sat_ff, sat_in;
   logic [31:0] integral_ff, integral_in;
   logic [16:0] last_error_ff, last_error_in;
   logic [15:0] last_drive_ff, last_drive_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_drive_ff, rsp_drive_in;
   logic        rsp_at_limit_ff, rsp_at_limit_in;
   logic        rsp_idle_flag_ff, rsp_idle_flag_in;

   logic        accept;
   logic        out_free;
   logic signed [16:0] err_new;
   logic signed [17:0] deriv_new;
   logic signed [18:0] integ_add;
   logic signed [32:0] integ_sum;
   logic signed [pidaw_pkg::RAW_W-1:0] raw;
   logic        raw_hi, raw_lo;

   pidaw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   pidaw_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .prod  (prod),
      .acc   (acc)
   );

   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Error, derivative and the windup test, formed at the transfer.
   assign err_new   = $signed({cfg.target[15], cfg.target})
                    - $signed({req_measured[15], req_measured});
   assign deriv_new = $signed({err_new[16], err_new})
                    - $signed({last_error_ff[16], last_error_ff});

   // Integral step: scaled error while the last drive sat at a limit, else the full error.
   assign integ_add = sat_ff ? $signed(prod[26:8])
                             : $signed({{2{err_ff[16]}}, err_ff});
   assign integ_sum = $signed({integral_ff[31], integral_ff})
                    + $signed({{14{integ_add[18]}}, integ_add});

   // Raw output is the accumulator floored by the Q8.8 fraction.
   assign raw    = acc[pidaw_pkg::ACC_W-1:pidaw_pkg::FRAC_W];
   assign raw_hi = raw > $signed(cfg.out_max);
   assign raw_lo = raw < $signed(cfg.out_min);

   // Sequencer driving the shared unit.
   always_comb begin
      state_in         = state_ff;
      err_in           = err_ff;
      deriv_in         = deriv_ff;
      sat_in           = sat_ff;
      integral_in      = integral_ff;
      last_error_in    = last_error_ff;
      last_drive_in    = last_drive_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_drive_in     = rsp_drive_ff;
      rsp_at_limit_in  = rsp_at_limit_ff;
      rsp_idle_flag_in = rsp_idle_flag_ff;
      mac_ctl.mul_a    = '0;
      mac_ctl.mul_b    = '0;
      mac_ctl.acc_op   = pidaw_pkg::ACC_HOLD;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cfg.run_enable) begin
                  err_in   = err_new;
                  deriv_in = deriv_new;
                  sat_in   = ($signed(last_drive_ff) >= $signed(cfg.out_max))
                          || ($signed(last_drive_ff) <= $signed(cfg.out_min));
                  state_in = S_WIND;
               end else begin
                  integral_in   = '0;
                  last_error_in = '0;
                  last_drive_in = '0;
                  state_in      = S_OFF;
               end
            end
         end
         S_WIND: begin
            mac_ctl.mul_a = {{15{err_ff[16]}}, err_ff};
            mac_ctl.mul_b = {8'd0, cfg.windup_factor};
            state_in      = S_INTEG;
         end
         S_INTEG: begin
            if (integ_sum[32] != integ_sum[31]) begin
               integral_in = integ_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
               integral_in = integ_sum[31:0];
            end
            mac_ctl.mul_a = {{15{err_ff[16]}}, err_ff};
            mac_ctl.mul_b = {cfg.gain_p[15], cfg.gain_p};
            state_in      = S_PI;
         end
         S_PI: begin
            mac_ctl.mul_a  = integral_ff;
            mac_ctl.mul_b  = {cfg.gain_i[15], cfg.gain_i};
            mac_ctl.acc_op = pidaw_pkg::ACC_LOAD;
            state_in       = S_PD;
         end
         S_PD: begin
            mac_ctl.mul_a  = {{14{deriv_ff[17]}}, deriv_ff};
            mac_ctl.mul_b  = {cfg.gain_d[15], cfg.gain_d};
            mac_ctl.acc_op = pidaw_pkg::ACC_ADD;
            state_in       = S_SUM;
         end
         S_SUM: begin
            mac_ctl.acc_op = pidaw_pkg::ACC_ADD;
            state_in       = S_CLAMP;
         end
         S_CLAMP: begin
            if (out_free) begin
               if (raw_hi) begin
                  rsp_drive_in = cfg.out_max;
               end else if (raw_lo) begin
                  rsp_drive_in = cfg.out_min;
               end else begin
                  rsp_drive_in = raw[15:0];
               end
               rsp_at_limit_in  = raw_hi || raw_lo;
               rsp_idle_flag_in = 1'b0;
               rsp_valid_in     = 1'b1;
               last_error_in    = err_ff;
               last_drive_in    = rsp_drive_in;
               state_in         = S_IDLE;
            end
         end
         S_OFF: begin
            if (out_free) begin
               rsp_drive_in     = '0;
               rsp_at_limit_in  = 1'b0;
               rsp_idle_flag_in = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state and loop memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         integral_ff   <= '0;
         last_error_ff <= '0;
         last_drive_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         integral_ff   <= integral_in;
         last_error_ff <= last_error_in;
         last_drive_ff <= last_drive_in;
      end
   end

   // Working operands and the result register.
   always_ff @(posedge clock) begin
      err_ff           <= err_in;
      deriv_ff         <= deriv_in;
      sat_ff           <= sat_in;
      rsp_drive_ff     <= rsp_drive_in;
      rsp_at_limit_ff  <= rsp_at_limit_in;
      rsp_idle_flag_ff <= rsp_idle_flag_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_at_limit  = rsp_at_limit_ff;
   assign rsp_idle_flag = rsp_idle_flag_ff;

endmodule

/* rtl/core/pidaw_checker.sv */
// Port-level checks for the PID controller, bound to its top level.
module pidaw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_drive,
   input logic        rsp_at_limit,
   input logic        rsp_idle_flag
);

   // The block works on one sample at a time: a transfer makes it busy.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a sample was in progress");

   // An idle result carries a zero drive and no limit flag.
   a_idle_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_idle_flag) |-> (rsp_drive == 16'd0 && !rsp_at_limit))
      else $error("idle result with nonzero drive or limit flag");

   // A stalled result holds.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drive)
                                    && $stable(rsp_at_limit) && $stable(rsp_idle_flag)))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (.*);
